// ----- design/itoa_pkg.sv -----
`default_nettype none

package itoa_pkg;

  // Fixed field widths
  localparam int BIN_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int HEX_DIGITS = BIN_W / 4;
  localparam int CNT_W      = 4;
  localparam int CHAR_W     = 8;
  localparam int MAX_CHARS  = 11;

  // Format kind codes
  typedef enum logic [1:0] {
    KIND_SDEC   = 2'd0,
    KIND_UDEC   = 2'd1,
    KIND_HEX_LO = 2'd2,
    KIND_HEX_UP = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT
  } state_t;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  // Converter control and status
  typedef struct packed {
    logic start;
  } dab_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  // One digit (0..15) to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] ext;
    begin
      ext  = {4'h0, d};
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d > 4'd9) begin
        digit_char = ext - 8'd10 + base;
      end else begin
        digit_char = ext + CH_ZERO;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/integer_to_ascii_digits_unit.sv -----
`default_nettype none

// Integer to ASCII digit stream. Each input transaction carries a 32-bit value and a
// format kind (signed decimal, unsigned decimal, lower or upper case hex); the block
// returns one output transaction per character, most significant digit first, with no
// leading zeros, a leading '-' for negative signed values, a running character count and
// a last flag on the final character. One number is handled at a time and in_stall stays
// high until its last character has been handed to the output register. Decimal values go
// through a bit-serial shift-and-add-3 converter that takes one bit per cycle, and then
// have their leading zeros dropped before the characters go out; hex skips the converter
// and goes straight to the leading-zero strip. An output stall holds back the next character.
module integer_to_ascii_digits_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [itoa_pkg::BIN_W-1:0]   in_value,
  input  wire logic [1:0]                   in_kind,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [itoa_pkg::CHAR_W-1:0]       out_char_code,
  output logic [itoa_pkg::CNT_W-1:0]        out_char_count,
  output logic                              out_last
);
  import itoa_pkg::*;

  state_t              state_r, state_nxt;
  logic [BCD_W-1:0]    dig_r, dig_nxt;
  logic [CNT_W-1:0]    ndig_r, ndig_nxt;
  logic                neg_r, neg_nxt;
  logic                upper_r, upper_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_code_r, out_code_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;

  dab_ctrl_t           dab_ctrl;
  dab_stat_t           dab_stat;
  logic [BCD_W-1:0]    dab_bcd;
  logic [BIN_W-1:0]    mag;
  logic                in_neg;
  logic                in_fire;
  logic                slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign in_neg    = (in_kind == KIND_SDEC) && in_value[BIN_W-1];
  assign mag       = in_neg ? BIN_W'(32'd0 - in_value) : in_value;
  assign slot_free = !out_valid_r || !out_stall;

  itoa_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dab_ctrl),
    .bin   (mag),
    .stat  (dab_stat),
    .bcd   (dab_bcd)
  );

  // Sequencer: convert, drop leading zeros, emit characters
  always_comb begin
    state_nxt      = state_r;
    dig_nxt        = dig_r;
    ndig_nxt       = ndig_r;
    neg_nxt        = neg_r;
    upper_nxt      = upper_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = (out_valid_r && out_stall);
    out_code_nxt   = out_code_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    dab_ctrl.start = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          neg_nxt   = in_neg;
          upper_nxt = (in_kind == KIND_HEX_UP);
          cnt_nxt   = '0;
          if (in_kind == KIND_HEX_LO || in_kind == KIND_HEX_UP) begin
            dig_nxt   = {in_value, {(BCD_W - BIN_W){1'b0}}};
            ndig_nxt  = CNT_W'(HEX_DIGITS);
            state_nxt = ST_STRIP;
          end else begin
            dab_ctrl.start = 1'b1;
            state_nxt      = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (dab_stat.done) begin
          dig_nxt   = dab_bcd;
          ndig_nxt  = CNT_W'(BCD_DIGITS);
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        // Drop one leading zero digit per cycle, keep at least one
        if (ndig_r > 4'd1 && dig_r[BCD_W-1 -: 4] == 4'h0) begin
          dig_nxt  = {dig_r[BCD_W-5:0], 4'h0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          out_count_nxt = cnt_r + 1'b1;
          if (neg_r) begin
            // Sign goes first; digits always follow
            out_code_nxt = CH_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_code_nxt = digit_char(dig_r[BCD_W-1 -: 4], upper_r);
            out_last_nxt = (ndig_r == 4'd1);
            dig_nxt      = {dig_r[BCD_W-5:0], 4'h0};
            ndig_nxt     = ndig_r - 1'b1;
            if (ndig_r == 4'd1) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dig_r       <= dig_nxt;
    ndig_r      <= ndig_nxt;
    neg_r       <= neg_nxt;
    upper_r     <= upper_nxt;
    cnt_r       <= cnt_nxt;
    out_code_r  <= out_code_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char_code  = out_code_r;
  assign out_char_count = out_count_r;
  assign out_last       = out_last_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("block ready right after accepting a transaction");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != 4'd0 && out_count_r <= CNT_W'(MAX_CHARS)))
    else $error("character count out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_r == CH_MINUS) |-> !out_last_r)
    else $error("sign emitted as final character");

  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT || state_r == ST_STRIP) |-> ndig_r != 4'd0)
    else $error("no digits left while emitting");

  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && !dab_stat.done) |-> dab_stat.busy)
    else $error("waiting on an idle converter");

endmodule

`default_nettype wire

// ----- design/itoa_dabble.sv -----
`default_nettype none

// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
module itoa_dabble (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire itoa_pkg::dab_ctrl_t        ctrl,
  input  wire logic [itoa_pkg::BIN_W-1:0] bin,
  output itoa_pkg::dab_stat_t             stat,
  output logic [itoa_pkg::BCD_W-1:0]      bcd
);
  import itoa_pkg::*;

  localparam int CNT_BITS = $clog2(BIN_W);
  localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(BIN_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [BIN_W-1:0]    bin_r;
  logic [BCD_W-1:0]    bcd_r;
  logic [BCD_W-1:0]    adj;
  logic [BCD_W-1:0]    bcd_nxt;

  // Add 3 to every digit of 5 or more, then shift in the next bit
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = 4'(bcd_r[4*i +: 4] + 4'd3);
      end
    end
    bcd_nxt = {adj[BCD_W-2:0], bin_r[BIN_W-1]};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_BIT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
      bcd_r <= bcd_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

`default_nettype wire
